>>> hdl/dual_mic_sound_activated_gate_macros.svh
// Assertion helpers for the sound-activated gate.
`ifndef DUAL_MIC_SOUND_ACTIVATED_GATE_MACROS_SVH
`define DUAL_MIC_SOUND_ACTIVATED_GATE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SAG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SAG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/sagate_pkg.sv
package sagate_pkg;

    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned THRESH_W    = 15;
    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [THRESH_W-1:0] LEVEL_THRESHOLD_RST = 15'd1000;
    localparam logic [COUNT_W-1:0]  SILENCE_LIMIT_RST   = 16'd68;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_LEVEL_THRESHOLD = 1'b0,
        CFG_SILENCE_LIMIT   = 1'b1
    } cfg_idx_t;

    // one buffer decision
    typedef struct packed {
        logic               out_channel;
        logic               keep_buffer;
        logic               recording_started;
        logic               recording_stopped;
        logic               flush_pending;
        logic [COUNT_W-1:0] session_number;
        logic               sound_seen;
    } result_t;

    // core status toward the output stage
    typedef struct packed {
        logic    produce;
        result_t res;
    } core_out_t;

endpackage

>>> hdl/dual_mic_sound_activated_gate.sv
// Sound-activated recording gate for two microphones.
// Input channel (s_valid/s_ready): one sample word per cycle while s_ready is
// high, tagged with its channel, a buffer-end mark and a stop request (looked
// at on buffer end only). Result channel (m_valid/m_ready): one decision word
// per buffer end, none for other samples. A decision is registered: it goes
// into the result register, or into the skid register if the result is held.
// Throughput: one sample per cycle while s_ready is high. The decision and all
// state updates are combinational, from the sample and per-channel state regs.
// A two-entry output stage (result register plus skid register) keeps the
// input open while one decision waits; s_ready drops only when both are full,
// i.e. after the receiver has stalled with two decisions pending.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (0: level
// threshold, 1: silence limit); write only while idle.
// Reset (aresetn, synchronous, active low) clears all channel state, empties
// the output stage and restores threshold 1000 and silence limit 68.
`include "dual_mic_sound_activated_gate_macros.svh"

module dual_mic_sound_activated_gate (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [0:0]                             cfg_addr,
    input  logic [sagate_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_channel,
    input  logic signed [sagate_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                   s_buffer_end,
    input  logic                                   s_stop_request,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_out_channel,
    output logic                                   m_keep_buffer,
    output logic                                   m_recording_started,
    output logic                                   m_recording_stopped,
    output logic                                   m_flush_pending,
    output logic [sagate_pkg::COUNT_W-1:0]         m_session_number,
    output logic                                   m_sound_seen
);
    import sagate_pkg::*;

    logic [THRESH_W-1:0] level_threshold_reg;
    logic [COUNT_W-1:0]  silence_limit_reg;
    logic                accept;
    logic                take;
    core_out_t           core_out;
    result_t             out_reg;
    result_t             skid_reg;
    logic                m_valid_reg;
    logic                skid_valid_reg;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign take    = m_valid_reg && m_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_threshold_reg <= LEVEL_THRESHOLD_RST;
            silence_limit_reg   <= SILENCE_LIMIT_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_LEVEL_THRESHOLD: level_threshold_reg <= cfg_wdata[THRESH_W-1:0];
                CFG_SILENCE_LIMIT:   silence_limit_reg   <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    sagate_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .channel         (s_channel),
        .sample          (s_sample),
        .buffer_end      (s_buffer_end),
        .stop_request    (s_stop_request),
        .level_threshold (level_threshold_reg),
        .silence_limit   (silence_limit_reg),
        .core_out        (core_out)
    );

    // output control: result register backed by a skid register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (core_out.produce) begin
            if (!m_valid_reg || take) begin
                m_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (take) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (take) begin
                out_reg <= skid_reg;
            end
        end else if (core_out.produce) begin
            if (!m_valid_reg || take) begin
                out_reg <= core_out.res;
            end else begin
                skid_reg <= core_out.res;
            end
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_out_channel       = out_reg.out_channel;
    assign m_keep_buffer       = out_reg.keep_buffer;
    assign m_recording_started = out_reg.recording_started;
    assign m_recording_stopped = out_reg.recording_stopped;
    assign m_flush_pending     = out_reg.flush_pending;
    assign m_session_number    = out_reg.session_number;
    assign m_sound_seen        = out_reg.sound_seen;

    // checks
    `SAG_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, m_valid_reg, "skid full with output empty")
    `SAG_ASSERT_NEXT(a_end_gives_word, accept && s_buffer_end, m_valid_reg, "buffer end lost")
    `SAG_ASSERT_NOW(a_flush_on_stop, m_valid_reg, m_flush_pending == m_recording_stopped, "flush differs from stop")
    `SAG_ASSERT_NOW(a_start_kept, m_valid_reg && m_recording_started, m_keep_buffer && m_sound_seen, "started buffer not kept")

endmodule

>>> hdl/sagate_core.sv
module sagate_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           accept,
    input  logic                           channel,
    input  logic signed [sagate_pkg::SAMPLE_W-1:0] sample,
    input  logic                           buffer_end,
    input  logic                           stop_request,
    input  logic [sagate_pkg::THRESH_W-1:0] level_threshold,
    input  logic [sagate_pkg::COUNT_W-1:0]  silence_limit,
    output sagate_pkg::core_out_t          core_out
);
    import sagate_pkg::*;

    logic [1:0]               above_seen_reg, above_seen_next;
    logic [1:0]               recording_reg, recording_next;
    logic [1:0]               ready_reg, ready_next;
    logic                     global_reg, global_next;
    logic [COUNT_W-1:0]       silence_reg [2];
    logic [COUNT_W-1:0]       silence_next [2];
    logic [COUNT_W-1:0]       session_reg [2];
    logic [COUNT_W-1:0]       session_next [2];

    logic [SAMPLE_W:0]        mag;
    logic                     above_now;
    logic                     above;
    logic                     trig;
    logic                     close;
    logic [COUNT_W-1:0]       sil;

    // sample magnitude; the most negative value gives 32768
    assign mag = sample[SAMPLE_W-1]
                 ? ((SAMPLE_W+1)'(1) << SAMPLE_W) - {1'b0, sample}
                 : {1'b0, sample};
    assign above_now = mag > {2'b00, level_threshold};

    // per-sample level tracking, per-buffer decision and state update
    always_comb begin
        above_seen_next = above_seen_reg;
        recording_next  = recording_reg;
        ready_next      = ready_reg;
        global_next     = global_reg;
        silence_next    = silence_reg;
        session_next    = session_reg;
        above           = above_seen_reg[channel] | above_now;
        trig            = 1'b0;
        close           = 1'b0;
        sil             = silence_reg[channel];
        core_out        = '0;
        core_out.res.out_channel = channel;

        if (accept) begin
            if (!buffer_end) begin
                above_seen_next[channel] = above;
            end else begin
                above_seen_next[channel] = 1'b0;
                core_out.produce         = 1'b1;
                core_out.res.sound_seen  = above;
                trig = !recording_reg[channel] && above;
                if (trig) begin
                    ready_next[channel] = 1'b1;
                end
                if (trig && !(ready_next[0] && ready_next[1])) begin
                    // other channel not ready yet: drop this buffer
                    core_out.res.session_number = session_reg[channel];
                end else begin
                    if (trig) begin
                        global_next            = 1'b1;
                        recording_next[channel] = 1'b1;
                        session_next[channel]  = session_reg[channel] + 1'b1;
                        core_out.res.recording_started = 1'b1;
                    end
                    core_out.res.keep_buffer = global_next;
                    // silence tracking, saturating
                    if (!above) begin
                        if (!trig && sil != '1) begin
                            sil = sil + 1'b1;
                        end else if (trig) begin
                            sil = COUNT_W'(1);
                        end
                        if (recording_next[channel] && sil > silence_limit) begin
                            close = 1'b1;
                        end
                    end else begin
                        sil = '0;
                    end
                    silence_next[channel] = sil;
                    if (stop_request && recording_next[channel]) begin
                        close = 1'b1;
                    end
                    if (close) begin
                        recording_next[channel] = 1'b0;
                        ready_next  = 2'b00;
                        global_next = 1'b0;
                    end
                    core_out.res.recording_stopped = close;
                    core_out.res.flush_pending     = close;
                    core_out.res.session_number    = session_next[channel];
                end
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            above_seen_reg <= '0;
            recording_reg  <= '0;
            ready_reg      <= '0;
            global_reg     <= 1'b0;
            silence_reg    <= '{default: '0};
            session_reg    <= '{default: '0};
        end else begin
            above_seen_reg <= above_seen_next;
            recording_reg  <= recording_next;
            ready_reg      <= ready_next;
            global_reg     <= global_next;
            silence_reg    <= silence_next;
            session_reg    <= session_next;
        end
    end

endmodule

>>> tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sagate_pkg::*;

    // one sample word as offered on the input channel
    typedef struct {
        logic                       channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       buffer_end;
        logic                       stop_request;
    } sample_word_t;

    // cycles with no word moving on either channel before the run is abandoned
    localparam int STALL_LIMIT = 5000;

    logic                       aclk;
    logic                       aresetn        = 1'b0;
    logic                       cfg_we         = 1'b0;
    logic [0:0]                 cfg_addr       = CFG_LEVEL_THRESHOLD;
    logic [CFG_DATA_W-1:0]      cfg_wdata      = '0;
    logic                       s_valid        = 1'b0;
    logic                       s_ready;
    logic                       s_channel      = 1'b0;
    logic signed [SAMPLE_W-1:0] s_sample       = '0;
    logic                       s_buffer_end   = 1'b0;
    logic                       s_stop_request = 1'b0;
    logic                       m_valid;
    logic                       m_ready        = 1'b0;
    logic                       m_out_channel;
    logic                       m_keep_buffer;
    logic                       m_recording_started;
    logic                       m_recording_stopped;
    logic                       m_flush_pending;
    logic [COUNT_W-1:0]         m_session_number;
    logic                       m_sound_seen;

    dual_mic_sound_activated_gate DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_addr            (cfg_addr),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_channel           (s_channel),
        .s_sample            (s_sample),
        .s_buffer_end        (s_buffer_end),
        .s_stop_request      (s_stop_request),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_out_channel       (m_out_channel),
        .m_keep_buffer       (m_keep_buffer),
        .m_recording_started (m_recording_started),
        .m_recording_stopped (m_recording_stopped),
        .m_flush_pending     (m_flush_pending),
        .m_session_number    (m_session_number),
        .m_sound_seen        (m_sound_seen)
    );

    // stimulus and scoreboard bookkeeping
    sample_word_t pending_words[$];
    result_t      expected_decisions[$];
    sample_word_t cur_word;
    int           gap_pct        = 0;
    int           stall_pct      = 0;
    int           gap_left       = 0;
    int           stall_left     = 0;
    int           errors         = 0;
    int           words_taken    = 0;
    int           decisions_seen = 0;
    int           settings_used  = 0;
    int           quiet_cycles   = 0;

    // gate state as the block should hold it
    logic [THRESH_W-1:0] thr_cfg = LEVEL_THRESHOLD_RST;
    logic [COUNT_W-1:0]  lim_cfg = SILENCE_LIMIT_RST;
    bit                  heard[2];
    bit                  rec_on[2];
    bit                  armed[2];
    bit                  session_open;
    logic [COUNT_W-1:0]  quiet_run[2]   = '{default: '0};
    logic [COUNT_W-1:0]  session_cnt[2] = '{default: '0};

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // closing ends this channel's recording, drops both ready flags and the shared flag
    function automatic void close_channel(int unsigned ch);
        rec_on[ch]   = 1'b0;
        armed[0]     = 1'b0;
        armed[1]     = 1'b0;
        session_open = 1'b0;
    endfunction

    // advance the gate by one sample word; returns 1 when a decision comes out
    function automatic bit decide_buffer(input sample_word_t w, output result_t r);
        logic [SAMPLE_W-1:0] mag;
        bit                  loud;
        int unsigned         ch;
        ch  = w.channel;
        mag = w.sample[SAMPLE_W-1] ? -w.sample : w.sample;
        if (mag > {1'b0, thr_cfg})
            heard[ch] = 1'b1;
        r = '0;
        r.out_channel = w.channel;
        if (!w.buffer_end)
            return 1'b0;

        loud      = heard[ch];
        heard[ch] = 1'b0;

        // sound while idle: arm, and start only once the other side is armed too
        if (!rec_on[ch] && loud) begin
            armed[ch] = 1'b1;
            if (armed[0] && armed[1]) begin
                session_open      = 1'b1;
                rec_on[ch]        = 1'b1;
                quiet_run[ch]     = '0;
                session_cnt[ch]   = session_cnt[ch] + 1'b1;
                r.recording_started = 1'b1;
            end else begin
                // buffer dropped, stop request not looked at
                r.session_number = session_cnt[ch];
                r.sound_seen     = 1'b1;
                return 1'b1;
            end
        end

        r.keep_buffer = session_open;

        // silence counter saturates; timeout only closes a live recording
        if (!loud) begin
            if (quiet_run[ch] != '1)
                quiet_run[ch] = quiet_run[ch] + 1'b1;
            if (rec_on[ch] && quiet_run[ch] > lim_cfg) begin
                close_channel(ch);
                r.recording_stopped = 1'b1;
                r.flush_pending     = 1'b1;
            end
        end else begin
            quiet_run[ch] = '0;
        end

        if (w.stop_request && rec_on[ch]) begin
            close_channel(ch);
            r.recording_stopped = 1'b1;
            r.flush_pending     = 1'b1;
        end

        r.session_number = session_cnt[ch];
        r.sound_seen     = loud;
        return 1'b1;
    endfunction

    // sample above or at/below the current threshold, either sign
    function automatic logic signed [SAMPLE_W-1:0] pick_sample(bit loud);
        int mag;
        if ($urandom_range(6, 0) == 0)
            mag = loud ? int'(thr_cfg) + 1 : int'(thr_cfg);
        else if (loud)
            mag = $urandom_range(32768, int'(thr_cfg) + 1);
        else
            mag = $urandom_range(int'(thr_cfg), 0);
        if (mag == 32768 || $urandom_range(1, 0) == 1)
            return SAMPLE_W'(-mag);
        return SAMPLE_W'(mag);
    endfunction

    function automatic void push_word(bit ch, logic signed [SAMPLE_W-1:0] smp,
                                      bit is_end, bit stop);
        sample_word_t w;
        w.channel      = ch;
        w.sample       = smp;
        w.buffer_end   = is_end;
        w.stop_request = stop;
        pending_words.push_back(w);
    endfunction

    // all queued words taken and every decision back, then let the pipe settle
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_words.size() != 0 || s_valid || expected_decisions.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // program both registers; only called while the gate is idle
    task automatic apply_setting(logic [CFG_DATA_W-1:0] thr_word,
                                 logic [CFG_DATA_W-1:0] lim_word);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_LEVEL_THRESHOLD;
        cfg_wdata <= thr_word;
        @(posedge aclk);
        cfg_addr  <= CFG_SILENCE_LIMIT;
        cfg_wdata <= lim_word;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        thr_cfg = thr_word[THRESH_W-1:0];
        lim_cfg = lim_word;
        settings_used++;
    endtask

    // one phase of random traffic: mostly whole buffers, some loose noise words
    task automatic random_phase(logic [CFG_DATA_W-1:0] thr_word,
                                logic [CFG_DATA_W-1:0] lim_word, int gap, int stall);
        int queued;
        int len;
        int hot;
        bit ch;
        bit loud;
        bit stop_end;
        apply_setting(thr_word, lim_word);
        gap_pct   = gap;
        stall_pct = stall;
        queued    = 0;
        while (queued < 90) begin
            if ($urandom_range(99, 0) < 20) begin
                push_word($urandom_range(1, 0), SAMPLE_W'($urandom), $urandom_range(1, 0),
                          $urandom_range(1, 0));
                queued++;
            end else begin
                len      = ($urandom_range(7, 0) == 0) ? $urandom_range(12, 4)
                                                       : $urandom_range(3, 1);
                ch       = $urandom_range(1, 0);
                loud     = $urandom_range(1, 0);
                stop_end = $urandom_range(99, 0) < 12;
                hot      = $urandom_range(len - 1, 0);
                for (int i = 0; i < len; i++)
                    push_word(ch, (loud && i == hot) ? pick_sample(1'b1)
                                  : pick_sample(loud && $urandom_range(3, 0) == 0),
                              i == len - 1,
                              (i == len - 1) ? stop_end : ($urandom_range(9, 0) == 0));
                queued += len;
            end
        end
        wait_idle();
    endtask

    // input driver: predict on acceptance, then offer the next word or idle
    always @(posedge aclk) begin : sample_driver
        result_t res;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                words_taken++;
                if (decide_buffer(cur_word, res))
                    expected_decisions.push_back(res);
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_words.size() != 0 && gap_pct != 0 &&
                             $urandom_range(99, 0) < gap_pct) begin
                    gap_left = $urandom_range(14, 1) - 1;
                    s_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    cur_word = pending_words.pop_front();
                    s_channel      <= cur_word.channel;
                    s_sample       <= cur_word.sample;
                    s_buffer_end   <= cur_word.buffer_end;
                    s_stop_request <= cur_word.stop_request;
                    s_valid        <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: check each decision against the oldest prediction
    always @(posedge aclk) begin : decision_monitor
        result_t got;
        result_t want;
        bit      bad;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_out_channel, m_keep_buffer, m_recording_started,
                       m_recording_stopped, m_flush_pending, m_session_number, m_sound_seen};
                decisions_seen++;
                if (expected_decisions.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: unexpected decision ch=%0d session=%0d",
                                 $realtime, got.out_channel, got.session_number);
                    errors++;
                end else begin
                    want = expected_decisions.pop_front();
                    bad  = (got.out_channel !== want.out_channel) ||
                           (got.keep_buffer !== want.keep_buffer) ||
                           (got.recording_started !== want.recording_started) ||
                           (got.recording_stopped !== want.recording_stopped) ||
                           (got.flush_pending !== want.flush_pending) ||
                           (got.session_number !== want.session_number) ||
                           (got.sound_seen !== want.sound_seen);
                    if (bad) begin
                        if (errors < 10) begin
                            $write("%0t: decision %0d exp ch=%0d keep=%0d start=%0d stop=%0d",
                                   $realtime, decisions_seen, want.out_channel,
                                   want.keep_buffer, want.recording_started,
                                   want.recording_stopped);
                            $display(" flush=%0d session=%0d sound=%0d", want.flush_pending,
                                     want.session_number, want.sound_seen);
                            $write("%0t: decision %0d got ch=%0d keep=%0d start=%0d stop=%0d",
                                   $realtime, decisions_seen, got.out_channel,
                                   got.keep_buffer, got.recording_started,
                                   got.recording_stopped);
                            $display(" flush=%0d session=%0d sound=%0d", got.flush_pending,
                                     got.session_number, got.sound_seen);
                        end
                        errors++;
                    end
                end
            end
            // receiver stalls in bursts
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
                stall_left = $urandom_range(14, 1) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog: nothing moving on either channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, threshold edge and the arming rules
        gap_pct   = 30;
        stall_pct = 30;
        push_word(0, 16'sd1000, 1, 0);        // at threshold is silence, idle count moves
        push_word(0, 16'sd1001, 0, 0);
        push_word(0, 16'sd0, 1, 1);           // arms ch0 alone: dropped, stop ignored
        push_word(0, 16'sd0, 1, 1);           // stop with no recording
        push_word(1, 16'sh8000, 1, 0);        // ch1 arms with both ready: starts
        push_word(0, -16'sd1001, 1, 0);       // ch0 starts too
        push_word(1, 16'sd32767, 0, 1);       // stop off buffer end has no effect
        push_word(1, 16'sd0, 1, 1);           // stop closes ch1 and the shared flag
        push_word(0, 16'sd5, 1, 0);           // ch0 still recording but not kept
        wait_idle();

        // top threshold (upper data bit dropped), zero silence limit
        apply_setting(16'hFFFF, 16'd0);
        push_word(0, 16'sd32767, 1, 0);       // silence timeout on ch0
        push_word(0, 16'sh8000, 1, 0);        // most negative still counts as sound
        wait_idle();

        apply_setting(16'd0, 16'hFFFF);
        push_word(1, 16'sd1, 1, 0);
        push_word(1, 16'sd0, 1, 0);
        push_word(0, -16'sd1, 1, 0);
        wait_idle();

        // random phases over several settings and idling mixes
        random_phase(16'd1000, 16'd68, 20, 20);
        random_phase(16'd0, 16'd0, 40, 0);
        random_phase(16'd32767, 16'hFFFF, 0, 40);
        random_phase(16'($urandom_range(3000, 1)), 16'($urandom_range(4, 1)), 25, 25);
        random_phase(16'd300, 16'd2, 0, 0);

        // no idling from here on: close any open recording, restart both sides
        gap_pct   = 0;
        stall_pct = 0;
        apply_setting(16'd1000, 16'd3);
        push_word(0, pick_sample(1'b0), 1, 1);
        push_word(1, pick_sample(1'b0), 1, 1);
        push_word(0, pick_sample(1'b1), 1, 0);
        push_word(1, pick_sample(1'b1), 1, 0);
        push_word(0, pick_sample(1'b1), 1, 0);
        // quiet ch1 buffers run into the silence limit
        for (int i = 0; i < 5; i++)
            push_word(1, pick_sample(1'b0), 1, 0);

        // start and stop ch0 over and over
        push_word(0, pick_sample(1'b0), 1, 1);
        for (int i = 0; i < 8; i++) begin
            push_word(1, pick_sample(1'b1), 1, 0);
            push_word(0, pick_sample(1'b1), 1, 1);
        end
        wait_idle();

        if (expected_decisions.size() != 0)
            errors++;
        $display("Run covered %0d sample words and %0d buffer decisions under %0d settings,",
                 words_taken, decisions_seen, settings_used);
        $display("including silence timeouts, stop requests and repeated session restarts.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
